[rtl/core/fractional_knapsack_greedy_assert.svh]
// Assertion macros used by the checker file of the knapsack block.
`ifndef FRACTIONAL_KNAPSACK_GREEDY_ASSERT_SVH
`define FRACTIONAL_KNAPSACK_GREEDY_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FKG_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FKG_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/fkg_pkg.sv]
// Package with the types and constants of the knapsack block.
package fkg_pkg;
   localparam int MAX_ITEMS = 64;
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int DIV_STEPS = 56;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [37:0] TOTAL_MAX = {38{1'b1}};

   typedef struct packed {
      logic [15:0] item_value;
      logic [15:0] item_weight;
      logic        item_last;
   } req_type;

   typedef struct packed {
      logic [37:0] total_value_q16;
      logic        partial_taken;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] value;
      logic [15:0] weight;
   } cell_type;

   typedef struct packed {
      logic insert;
      logic shift;
      logic clear;
   } ctl_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FILL,
      ST_MUL,
      ST_DIVGO,
      ST_DIV,
      ST_DONE
   } state_type;
endpackage

[rtl/core/fkg_cell.sv]
// One cell of the sorted insertion chain.
module fkg_cell (
   input  logic              clock,
   input  logic              reset,
   input  fkg_pkg::ctl_type  ctl,
   input  fkg_pkg::cell_type new_item,
   input  fkg_pkg::cell_type prev_item,
   input  fkg_pkg::cell_type next_item,
   input  logic              h_prev,
   output fkg_pkg::cell_type cell_q,
   output logic              h_out
);
   import fkg_pkg::*;

   cell_type    cell_ff;
   cell_type    cell_in;
   logic [31:0] lhs;
   logic [31:0] rhs;

   assign lhs = 32'(new_item.value) * 32'(cell_ff.weight);
   assign rhs = 32'(cell_ff.value) * 32'(new_item.weight);
   assign h_out = !cell_ff.valid || (lhs > rhs);
   assign cell_q = cell_ff;

   always_comb begin
      cell_in = cell_ff;
      priority if (ctl.clear) begin
         cell_in.valid = 1'b0;
      end else if (ctl.shift) begin
         cell_in = next_item;
      end else if (ctl.insert && h_out && !h_prev) begin
         cell_in = new_item;
      end else if (ctl.insert && h_out && h_prev) begin
         cell_in = prev_item;
      end else begin
         cell_in = cell_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff <= cell_in;
      end
   end
endmodule

[rtl/core/fkg_div.sv]
// Restoring divider for the partial item, one quotient bit per cycle.
module fkg_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [39:0] numer,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   import fkg_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [15:0]          rem_ff;
   logic [55:0]          dvd_ff;
   logic [31:0]          q_ff;
   logic [16:0]          rem_try;
   logic                 qbit;
   logic [16:0]          rem_sub;

   assign rem_try = {rem_ff, dvd_ff[55]};
   assign qbit = rem_try >= {1'b0, divisor};
   assign rem_sub = qbit ? (rem_try - {1'b0, divisor}) : rem_try;
   assign done = done_ff;
   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
            rem_ff <= '0;
            dvd_ff <= {numer, 16'd0};
            q_ff <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_sub[15:0];
            dvd_ff <= {dvd_ff[54:0], 1'b0};
            q_ff <= {q_ff[30:0], qbit};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

[rtl/core/fractional_knapsack_greedy.sv]
// Top level of the greedy fractional knapsack block.
// Items enter on the req channel, one transfer per cycle while req is not
// stalled, each a value, a weight and a last flag. A zero weight counts as
// one. Each item is placed into a chain of cells that keeps the set ordered
// by value per weight, highest first, with equal ratios in arrival order.
// Items beyond the chain length are dropped. After the transfer that carries
// the last flag, the block stalls req and fills the knapsack: the chain
// shifts its head out once per cycle, one whole item taken per shift. The
// first item that does not fit, if capacity remains, is split by a multiply
// step, a divider start step, the restoring division and a step to flag the
// quotient. Each set gives a single result on rsp. The result register
// holds while rsp is stalled, and the next set may load meanwhile; a new
// result waits until the register is free. The capacity is written on the
// csr channel, which is always ready. Reset clears the chain, the count,
// the capacity and rsp.
module fractional_knapsack_greedy (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fkg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fkg_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [23:0]      csr_data
);
   import fkg_pkg::*;

   state_type        state_ff;
   state_type        state_in;
   logic [23:0]      cap_ff;
   logic [CNT_W-1:0] count_ff;
   req_type          s0_ff;
   logic             s0_valid_ff;
   logic             s0_ins_ff;
   logic [23:0]      used_ff;
   logic [37:0]      total_ff;
   logic             partial_ff;
   logic [15:0]      pv_ff;
   logic [15:0]      pw_ff;
   logic [23:0]      rcap_ff;
   logic [39:0]      prod_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   ctl_type          ctl;
   cell_type         new_item;
   cell_type         cells [MAX_ITEMS];
   logic             h [MAX_ITEMS];
   logic             accept;
   logic             not_full;
   logic [15:0]      fixed_w;
   logic [24:0]      sum_w;
   logic             fits;
   logic [23:0]      remain;
   logic             out_free;
   logic             div_done;
   logic [31:0]      quotient;
   logic             add_en;
   logic [37:0]      addend;
   logic [38:0]      total_sum;
   logic             take_whole;
   logic             take_part;
   logic             publish;

   assign csr_ready = 1'b1;
   assign req_stall = !(state_ff == ST_LOAD && !(s0_valid_ff && s0_ff.item_last));
   assign accept = req_valid && !req_stall;
   assign not_full = count_ff < CNT_W'(MAX_ITEMS);
   assign fixed_w = (req_data.item_weight == 16'd0) ? 16'd1 : req_data.item_weight;
   assign new_item = '{valid: 1'b1, value: s0_ff.item_value, weight: s0_ff.item_weight};
   assign sum_w = {1'b0, used_ff} + {9'd0, cells[0].weight};
   assign fits = sum_w <= {1'b0, cap_ff};
   assign remain = cap_ff - used_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign total_sum = {1'b0, total_ff} + {1'b0, addend};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      cell_type prev_c;
      cell_type next_c;
      logic     h_prev_c;
      if (i == 0) begin : g_head
         assign prev_c = '0;
         assign h_prev_c = 1'b0;
      end else begin : g_body
         assign prev_c = cells[i-1];
         assign h_prev_c = h[i-1];
      end
      if (i == MAX_ITEMS - 1) begin : g_tail
         assign next_c = '0;
      end else begin : g_inner
         assign next_c = cells[i+1];
      end
      fkg_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .new_item (new_item),
         .prev_item(prev_c),
         .next_item(next_c),
         .h_prev   (h_prev_c),
         .cell_q   (cells[i]),
         .h_out    (h[i])
      );
   end

   fkg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == ST_DIVGO),
      .numer   (prod_ff),
      .divisor (pw_ff),
      .done    (div_done),
      .quotient(quotient)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (s0_valid_ff && s0_ff.item_last) state_in = ST_FILL;
         end
         ST_FILL: begin
            priority if (!cells[0].valid) state_in = ST_DONE;
            else if (fits) state_in = ST_FILL;
            else if (remain == 24'd0) state_in = ST_DONE;
            else state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_DIVGO;
         ST_DIVGO: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      ctl = '0;
      take_whole = 1'b0;
      take_part = 1'b0;
      publish = 1'b0;
      unique case (state_ff)
         ST_LOAD: ctl.insert = s0_valid_ff && s0_ins_ff;
         ST_FILL: begin
            take_whole = cells[0].valid && fits;
            take_part = cells[0].valid && !fits && (remain != 24'd0);
            ctl.shift = take_whole;
         end
         ST_DONE: begin
            publish = out_free;
            ctl.clear = out_free;
         end
         default: ctl = '0;
      endcase
      add_en = take_whole || (state_ff == ST_DIV && div_done);
      addend = take_whole ? {6'd0, cells[0].value, 16'd0} : {6'd0, quotient};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cap_ff <= '0;
         count_ff <= '0;
         s0_valid_ff <= 1'b0;
         used_ff <= '0;
         total_ff <= '0;
         partial_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) cap_ff <= csr_data;
         s0_valid_ff <= accept;
         if (accept) begin
            s0_ff <= '{item_value: req_data.item_value, item_weight: fixed_w,
                       item_last: req_data.item_last};
            s0_ins_ff <= not_full;
            if (not_full) count_ff <= count_ff + 1'b1;
         end
         if (take_whole) used_ff <= sum_w[23:0];
         if (add_en) total_ff <= total_sum[38] ? TOTAL_MAX : total_sum[37:0];
         if (take_part) begin
            pv_ff <= cells[0].value;
            pw_ff <= cells[0].weight;
            rcap_ff <= remain;
         end
         if (state_ff == ST_MUL) prod_ff <= 40'(pv_ff) * 40'(rcap_ff);
         if (state_ff == ST_DIV && div_done) partial_ff <= 1'b1;
         if (rsp_valid_ff && !rsp_stall && !publish) rsp_valid_ff <= 1'b0;
         if (publish) begin
            rsp_ff <= '{total_value_q16: total_ff, partial_taken: partial_ff};
            rsp_valid_ff <= 1'b1;
            count_ff <= '0;
            used_ff <= '0;
            total_ff <= '0;
            partial_ff <= 1'b0;
         end
      end
   end
endmodule

[rtl/core/fkg_checker.sv]
// Port checker for the knapsack block and its bind to the top level.
`include "fractional_knapsack_greedy_assert.svh"

module fkg_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input fkg_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fkg_pkg::rsp_type rsp_data,
   input logic             csr_valid,
   input logic             csr_ready,
   input logic [23:0]      csr_data
);
   `FKG_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data),
      "stalled result changed")
   `FKG_ASSERT_NXT(a_last_stalls, req_valid && !req_stall && req_data.item_last,
      req_stall, "input taken right after a last transfer")
   `FKG_ASSERT_IMP(a_rsp_after_busy, $rose(rsp_valid), $past(req_stall),
      "result appeared while input was open")
endmodule

bind fractional_knapsack_greedy fkg_checker u_fkg_checker (.*);

[tb/fractional_knapsack_greedy_test.sv]
// Testbench for the greedy fractional knapsack block: directed and random item sets.
`timescale 1ns / 100ps

module fractional_knapsack_greedy_test;
   import fkg_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [23:0] csr_data = '0;

   logic [23:0] knap_capacity = '0;
   logic [15:0] set_values[$];
   logic [15:0] set_weights[$];
   rsp_type     totals_pending[$];
   int          errors = 0;
   int          burst_left = 0;

   fractional_knapsack_greedy u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   function automatic rsp_type knapsack_total();
      logic [15:0] vals[$];
      logic [15:0] wts[$];
      logic [63:0] total, used, remain;
      int          k;
      rsp_type     r;
      for (int i = 0; i < set_values.size(); i++) begin
         k = vals.size();
         while (k > 0 && 64'(set_values[i]) * wts[k-1] > 64'(vals[k-1]) * set_weights[i])
            k--;
         vals.insert(k, set_values[i]);
         wts.insert(k, set_weights[i]);
      end
      total = 0;
      used = 0;
      r = '0;
      for (int i = 0; i < vals.size(); i++) begin
         if (used + wts[i] <= knap_capacity) begin
            used += wts[i];
            total += 64'(vals[i]) << 16;
         end else begin
            remain = knap_capacity - used;
            if (remain > 0) begin
               total += ((64'(vals[i]) * remain) << 16) / wts[i];
               r.partial_taken = 1'b1;
            end
            break;
         end
      end
      if (total > 64'(TOTAL_MAX)) total = 64'(TOTAL_MAX);
      r.total_value_q16 = total[37:0];
      return r;
   endfunction

   task automatic send_item(input logic [15:0] v, input logic [15:0] w, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(4);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= '{item_value: v, item_weight: w, item_last: last};
      do @(posedge clock); while (req_stall);
      if (set_values.size() < MAX_ITEMS) begin
         set_values.push_back(v);
         set_weights.push_back(w == 0 ? 16'd1 : w);
      end
      if (last) begin
         totals_pending.push_back(knapsack_total());
         set_values.delete();
         set_weights.delete();
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (totals_pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [23:0] c);
      drain();
      csr_valid <= 1'b1;
      csr_data <= c;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      knap_capacity = c;
   endtask

   task automatic random_set(input int n);
      for (int i = 0; i < n; i++)
         send_item(16'($urandom),
                   ($urandom_range(3) == 0) ? 16'($urandom_range(8)) : 16'($urandom),
                   i == n - 1);
   endtask

   task automatic test_directed();
      write_capacity(24'd100);
      send_item(16'hFFFF, 16'hFFFF, 1'b1);
      send_item(16'd0, 16'd0, 1'b0);
      send_item(16'd10, 16'd10, 1'b0);
      send_item(16'd20, 16'd20, 1'b0);
      send_item(16'd60, 16'd30, 1'b1);
      send_item(16'd5, 16'd50, 1'b0);
      send_item(16'd7, 16'd50, 1'b1);
      write_capacity(24'd0);
      send_item(16'd9, 16'd3, 1'b0);
      send_item(16'hFFFF, 16'd1, 1'b1);
      write_capacity(24'hFFFFFF);
      send_item(16'hFFFF, 16'd1, 1'b0);
      send_item(16'hAAAA, 16'h5555, 1'b1);
      write_capacity(24'd5);
      send_item(16'd3, 16'd5, 1'b0);
      send_item(16'd8, 16'd7, 1'b1);
   endtask

   task automatic test_store_full();
      write_capacity(24'd300000);
      for (int i = 0; i < 70; i++)
         send_item(16'($urandom), 16'($urandom_range(1, 16'hFFFF)), i == 69);
      drain();
      for (int i = 0; i < 64; i++) send_item(16'($urandom), 16'($urandom), 1'b0);
      send_item(16'hFFFF, 16'd1, 1'b1);
   endtask

   task automatic test_random();
      logic [23:0] caps[5] = '{24'd0, 24'd1, 24'd1000, 24'd70000, 24'hFFFFFF};
      for (int ph = 0; ph < 5; ph++) begin
         write_capacity(caps[ph]);
         for (int s = 0; s < 32; s++) random_set($urandom_range(1, 12));
      end
      write_capacity(24'($urandom));
      for (int s = 0; s < 20; s++) random_set($urandom_range(1, 30));
      drain();
   endtask

   always @(posedge clock) begin
      if (reset || $urandom_range(9) < 6 || ($time / 4000) % 3 == 0) rsp_stall <= 1'b0;
      else rsp_stall <= 1'b1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (totals_pending.size() == 0) begin
            $error("unexpected result %h", rsp_data);
            errors++;
         end else begin
            if (rsp_data.total_value_q16 !== totals_pending[0].total_value_q16) begin
               $error("total_value_q16 expected %h actual %h",
                      totals_pending[0].total_value_q16, rsp_data.total_value_q16);
               errors++;
            end
            if (rsp_data.partial_taken !== totals_pending[0].partial_taken) begin
               $error("partial_taken expected %b actual %b",
                      totals_pending[0].partial_taken, rsp_data.partial_taken);
               errors++;
            end
            void'(totals_pending.pop_front());
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_store_full();
      test_random();
      if (errors == 0 && totals_pending.size() == 0)
         $display("fractional_knapsack_greedy_test: done, clean");
      else
         $display("fractional_knapsack_greedy_test: done, errors");
      $finish;
   end

   initial begin
      #8000000;
      $display("fractional_knapsack_greedy_test: done, errors");
      $finish;
   end
endmodule
